// ===== rtl/bpor_pkg.sv =====
// ----------------------------------------------------------------------------
// bpor_pkg: shared types and constants of the block partition owner router
// widths, register codes and the records that travel between pipeline parts
// ----------------------------------------------------------------------------
`default_nettype none

package bpor_pkg;

   // partition limits
   localparam int MAX_PAIRS  = 1048576;
   localparam int MAX_STATES = 4096;
   localparam int MAX_RANKS  = 1024;

   // field widths
   localparam int COORD_W = 24;
   localparam int VALUE_W = 64;
   localparam int OWNER_W = 10;
   localparam int FLAT_W  = 32;

   // register widths
   localparam int PAIR_COUNT_W  = 21;
   localparam int STATE_COUNT_W = 13;
   localparam int RANK_COUNT_W  = 11;

   // clamped counts and the indices below them
   localparam int NP_W    = $clog2(MAX_PAIRS + 1);
   localparam int NS_W    = $clog2(MAX_STATES + 1);
   localparam int NR_W    = $clog2(MAX_RANKS + 1);
   localparam int PAIR_W  = $clog2(MAX_PAIRS);
   localparam int STATE_W = $clog2(MAX_STATES);

   // register port
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = CSR_ADDR_W - 2;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_ROW_START    = 3'd0,
      REG_COLUMN_START = 3'd1,
      REG_PAIR_COUNT   = 3'd2,
      REG_STATE_COUNT  = 3'd3,
      REG_RANK_COUNT   = 3'd4
   } reg_index_type;

   typedef struct packed {
      logic [VALUE_W-1:0] re;
      logic [VALUE_W-1:0] im;
   } value_type;

   typedef struct packed {
      logic [COORD_W-1:0] elem_row;
      logic [COORD_W-1:0] global_col;
      logic [VALUE_W-1:0] value_re_bits;
      logic [VALUE_W-1:0] value_im_bits;
   } req_type;

   typedef struct packed {
      logic               in_block;
      logic [OWNER_W-1:0] owner_rank;
      logic [FLAT_W-1:0]  flat_index;
      logic [VALUE_W-1:0] out_re_bits;
      logic [VALUE_W-1:0] out_im_bits;
   } rsp_type;

   // partition settings seen by the datapath
   typedef struct packed {
      logic [COORD_W-1:0] row_start;
      logic [COORD_W-1:0] column_start;
      logic [NP_W-1:0]    np;
      logic [NS_W-1:0]    ns;
      logic [NP_W-1:0]    base;
      logic [OWNER_W-1:0] rem;
      logic [NP_W-1:0]    wide_end;
   } cfg_type;

   // record through the owner divider
   typedef struct packed {
      logic               in_win;
      logic               low_part;
      logic [PAIR_W-1:0]  pair;
      logic [STATE_W-1:0] state;
      logic [PAIR_W-1:0]  rmd;
      logic [NP_W-1:0]    divisor;
      logic [OWNER_W-1:0] quot;
      value_type          value;
   } div_type;

endpackage

`default_nettype wire

// ===== rtl/bpor_req_if.sv =====
// ----------------------------------------------------------------------------
// bpor_req_if: request channel
// valid/ready handshake carrying one matrix element
// ----------------------------------------------------------------------------
`default_nettype none

interface bpor_req_if;
   import bpor_pkg::*;

   logic               valid;
   logic               ready;
   logic [COORD_W-1:0] elem_row;
   logic [COORD_W-1:0] global_col;
   logic [VALUE_W-1:0] value_re_bits;
   logic [VALUE_W-1:0] value_im_bits;

   modport source (
      output valid, output elem_row, output global_col,
      output value_re_bits, output value_im_bits,
      input  ready
   );

   modport sink (
      input  valid, input elem_row, input global_col,
      input  value_re_bits, input value_im_bits,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/bpor_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bpor_rsp_if: response channel
// valid/ready handshake carrying owner, local index and value
// ----------------------------------------------------------------------------
`default_nettype none

interface bpor_rsp_if;
   import bpor_pkg::*;

   logic               valid;
   logic               ready;
   logic               in_block;
   logic [OWNER_W-1:0] owner_rank;
   logic [FLAT_W-1:0]  flat_index;
   logic [VALUE_W-1:0] out_re_bits;
   logic [VALUE_W-1:0] out_im_bits;

   modport source (
      output valid, output in_block, output owner_rank, output flat_index,
      output out_re_bits, output out_im_bits,
      input  ready
   );

   modport sink (
      input  valid, input in_block, input owner_rank, input flat_index,
      input  out_re_bits, input out_im_bits,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/bpor_cfg.sv =====
// ----------------------------------------------------------------------------
// bpor_cfg: register file and partition setup
// apb registers, count clamping and a serial divider for base and remainder
// ----------------------------------------------------------------------------
`default_nettype none

module bpor_cfg (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [bpor_pkg::CSR_ADDR_W-1:0]    paddr,
   input  logic [bpor_pkg::CSR_DATA_W-1:0]    pwdata,
   output logic [bpor_pkg::CSR_DATA_W-1:0]    prdata,
   output logic                               pready,
   output bpor_pkg::cfg_type                  cfg,
   output logic                               busy
);
   import bpor_pkg::*;

   localparam int CNT_W = $clog2(NP_W);

   typedef enum logic [1:0] {
      CFG_IDLE,
      CFG_LOAD,
      CFG_DIV,
      CFG_FINISH
   } cfg_state_type;

   logic [COORD_W-1:0]       row_start_ff;
   logic [COORD_W-1:0]       column_start_ff;
   logic [PAIR_COUNT_W-1:0]  pair_count_ff;
   logic [STATE_COUNT_W-1:0] state_count_ff;
   logic [RANK_COUNT_W-1:0]  rank_count_ff;

   reg_index_type            reg_index;
   logic                     wr_en;
   logic [NP_W-1:0]          np;
   logic [NS_W-1:0]          ns;
   logic [NR_W-1:0]          nr;

   cfg_state_type            state_ff;
   logic [NP_W-1:0]          dq_ff;
   logic [NR_W-1:0]          dr_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [NP_W-1:0]          base_ff;
   logic [OWNER_W-1:0]       rem_ff;
   logic [NP_W-1:0]          wide_end_ff;

   logic [NR_W:0]            trial;
   logic                     ge;
   logic [NP_W-1:0]          base_inc;
   logic [NP_W+OWNER_W-1:0]  le_prod;

   assign reg_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en     = psel & penable & pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_start_ff    <= '0;
         column_start_ff <= '0;
         pair_count_ff   <= PAIR_COUNT_W'(1);
         state_count_ff  <= STATE_COUNT_W'(1);
         rank_count_ff   <= RANK_COUNT_W'(1);
      end else if (wr_en) begin
         case (reg_index)
            REG_ROW_START:    row_start_ff    <= pwdata[COORD_W-1:0];
            REG_COLUMN_START: column_start_ff <= pwdata[COORD_W-1:0];
            REG_PAIR_COUNT:   pair_count_ff   <= pwdata[PAIR_COUNT_W-1:0];
            REG_STATE_COUNT:  state_count_ff  <= pwdata[STATE_COUNT_W-1:0];
            REG_RANK_COUNT:   rank_count_ff   <= pwdata[RANK_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_ROW_START:    prdata = CSR_DATA_W'(row_start_ff);
         REG_COLUMN_START: prdata = CSR_DATA_W'(column_start_ff);
         REG_PAIR_COUNT:   prdata = CSR_DATA_W'(pair_count_ff);
         REG_STATE_COUNT:  prdata = CSR_DATA_W'(state_count_ff);
         REG_RANK_COUNT:   prdata = CSR_DATA_W'(rank_count_ff);
         default:          prdata = '0;
      endcase
   end

   // zero counts as one, large counts saturate
   always_comb begin
      if (pair_count_ff == '0) begin
         np = NP_W'(1);
      end else if (NP_W'(pair_count_ff) > NP_W'(MAX_PAIRS)) begin
         np = NP_W'(MAX_PAIRS);
      end else begin
         np = NP_W'(pair_count_ff);
      end
      if (state_count_ff == '0) begin
         ns = NS_W'(1);
      end else if (NS_W'(state_count_ff) > NS_W'(MAX_STATES)) begin
         ns = NS_W'(MAX_STATES);
      end else begin
         ns = NS_W'(state_count_ff);
      end
      if (rank_count_ff == '0) begin
         nr = NR_W'(1);
      end else if (NR_W'(rank_count_ff) > NR_W'(MAX_RANKS)) begin
         nr = NR_W'(MAX_RANKS);
      end else begin
         nr = NR_W'(rank_count_ff);
      end
   end

   // restoring division step, one quotient bit per cycle
   assign trial    = {dr_ff, dq_ff[NP_W-1]};
   assign ge       = trial >= {1'b0, nr};
   assign base_inc = dq_ff + 1'b1;
   assign le_prod  = base_inc * dr_ff[OWNER_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= CFG_IDLE;
         base_ff     <= NP_W'(1);
         rem_ff      <= '0;
         wide_end_ff <= '0;
      end else if (wr_en) begin
         state_ff <= CFG_LOAD;
      end else begin
         case (state_ff)
            CFG_IDLE: ;
            CFG_LOAD: begin
               dq_ff    <= np;
               dr_ff    <= '0;
               cnt_ff   <= CNT_W'(NP_W - 1);
               state_ff <= CFG_DIV;
            end
            CFG_DIV: begin
               dq_ff <= {dq_ff[NP_W-2:0], ge};
               if (ge) begin
                  dr_ff <= NR_W'(trial - {1'b0, nr});
               end else begin
                  dr_ff <= trial[NR_W-1:0];
               end
               cnt_ff <= cnt_ff - 1'b1;
               if (cnt_ff == '0) begin
                  state_ff <= CFG_FINISH;
               end
            end
            CFG_FINISH: begin
               base_ff     <= dq_ff;
               rem_ff      <= dr_ff[OWNER_W-1:0];
               wide_end_ff <= le_prod[NP_W-1:0];
               state_ff    <= CFG_IDLE;
            end
            default: state_ff <= CFG_IDLE;
         endcase
      end
   end

   assign busy = (state_ff != CFG_IDLE);

   always_comb begin
      cfg.row_start    = row_start_ff;
      cfg.column_start = column_start_ff;
      cfg.np           = np;
      cfg.ns           = ns;
      cfg.base         = base_ff;
      cfg.rem          = rem_ff;
      cfg.wide_end     = wide_end_ff;
   end

endmodule

`default_nettype wire

// ===== rtl/bpor_front.sv =====
// ----------------------------------------------------------------------------
// bpor_front: block test and divider setup
// two stages: window compare, then dividend and divisor selection
// ----------------------------------------------------------------------------
`default_nettype none

module bpor_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bpor_pkg::req_type in_data,
   input  bpor_pkg::cfg_type cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output bpor_pkg::div_type out_data
);
   import bpor_pkg::*;

   typedef struct packed {
      logic               in_win;
      logic [PAIR_W-1:0]  pair;
      logic [STATE_W-1:0] state;
      value_type          value;
   } locate_type;

   locate_type         s1_ff, s1_in;
   logic               s1_v_ff;
   div_type            s2_ff, s2_in;
   logic               s2_v_ff;
   logic               en1, en2;
   logic [COORD_W:0]   row_diff, col_diff;
   logic               row_hit, col_hit, low_part;
   logic [NP_W-1:0]    pair_ext;

   assign en2      = !s2_v_ff || out_ready;
   assign en1      = !s1_v_ff || en2;
   assign in_ready = en1;

   assign row_diff = {1'b0, in_data.elem_row} - {1'b0, cfg.row_start};
   assign col_diff = {1'b0, in_data.global_col} - {1'b0, cfg.column_start};
   assign row_hit  = !row_diff[COORD_W] && (row_diff[COORD_W-1:0] < COORD_W'(cfg.np));
   assign col_hit  = !col_diff[COORD_W] && (col_diff[COORD_W-1:0] < COORD_W'(cfg.ns));

   always_comb begin
      s1_in.in_win   = row_hit && col_hit;
      s1_in.pair     = row_diff[PAIR_W-1:0];
      s1_in.state    = col_diff[STATE_W-1:0];
      s1_in.value.re = in_data.value_re_bits;
      s1_in.value.im = in_data.value_im_bits;
   end

   // pairs below wide_end belong to ranks holding base+1 pairs
   assign pair_ext = NP_W'(s1_ff.pair);
   assign low_part = pair_ext < cfg.wide_end;

   always_comb begin
      s2_in.in_win   = s1_ff.in_win;
      s2_in.low_part = low_part;
      s2_in.pair     = s1_ff.pair;
      s2_in.state    = s1_ff.state;
      s2_in.quot     = '0;
      s2_in.value    = s1_ff.value;
      if (low_part) begin
         s2_in.rmd     = s1_ff.pair;
         s2_in.divisor = NP_W'(cfg.base + 1'b1);
      end else begin
         s2_in.rmd     = PAIR_W'(pair_ext - cfg.wide_end);
         s2_in.divisor = cfg.base;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            s1_v_ff <= in_valid;
         end
         if (en2) begin
            s2_v_ff <= s1_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         s1_ff <= s1_in;
      end
      if (en2 && s1_v_ff) begin
         s2_ff <= s2_in;
      end
   end

   assign out_valid = s2_v_ff;
   assign out_data  = s2_ff;

endmodule

`default_nettype wire

// ===== rtl/bpor_divider.sv =====
// ----------------------------------------------------------------------------
// bpor_divider: pipelined owner divider
// one restoring step per stage, quotient bits from the top down
// ----------------------------------------------------------------------------
`default_nettype none

module bpor_divider (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bpor_pkg::div_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output bpor_pkg::div_type out_data
);
   import bpor_pkg::*;

   localparam int SH_W = NP_W + OWNER_W;

   div_type            st_ff  [OWNER_W];
   div_type            st_in  [OWNER_W];
   div_type            src    [OWNER_W];
   logic [OWNER_W-1:0] v_ff;
   logic [OWNER_W-1:0] src_v;
   logic [OWNER_W-1:0] en;

   always_comb begin
      src[0]   = in_data;
      src_v[0] = in_valid;
      for (int k = 1; k < OWNER_W; k++) begin
         src[k]   = st_ff[k-1];
         src_v[k] = v_ff[k-1];
      end
   end

   // stage k decides quotient bit OWNER_W-1-k
   always_comb begin
      logic [SH_W-1:0] trial_div;
      logic [SH_W-1:0] rmd_ext;
      for (int k = 0; k < OWNER_W; k++) begin
         trial_div = SH_W'(src[k].divisor) << (OWNER_W - 1 - k);
         rmd_ext   = SH_W'(src[k].rmd);
         st_in[k]  = src[k];
         if (rmd_ext >= trial_div) begin
            st_in[k].rmd                   = PAIR_W'(rmd_ext - trial_div);
            st_in[k].quot[OWNER_W - 1 - k] = 1'b1;
         end
      end
   end

   always_comb begin
      en[OWNER_W-1] = !v_ff[OWNER_W-1] || out_ready;
      for (int k = OWNER_W - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         for (int k = 0; k < OWNER_W; k++) begin
            if (en[k]) begin
               v_ff[k] <= src_v[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < OWNER_W; k++) begin
         if (en[k] && src_v[k]) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[OWNER_W-1];
   assign out_data  = st_ff[OWNER_W-1];

endmodule

`default_nettype wire

// ===== rtl/bpor_back.sv =====
// ----------------------------------------------------------------------------
// bpor_back: owner range and local index
// three stages: owner select, products, final sum into the response register
// ----------------------------------------------------------------------------
`default_nettype none

module bpor_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  bpor_pkg::div_type in_data,
   input  bpor_pkg::cfg_type cfg,
   output logic              out_valid,
   input  logic              out_ready,
   output bpor_pkg::rsp_type out_data
);
   import bpor_pkg::*;

   typedef struct packed {
      logic               in_win;
      logic [PAIR_W-1:0]  pair;
      logic [STATE_W-1:0] state;
      logic [OWNER_W-1:0] owner;
      logic [OWNER_W-1:0] minv;
      logic [NP_W-1:0]    count;
      value_type          value;
   } owner_type;

   typedef struct packed {
      logic               in_win;
      logic [PAIR_W-1:0]  pair;
      logic [OWNER_W-1:0] owner;
      logic [OWNER_W-1:0] minv;
      logic [FLAT_W-1:0]  prod_state;
      logic [FLAT_W-1:0]  prod_first;
      value_type          value;
   } product_type;

   owner_type                 b1_ff, b1_in;
   product_type               b2_ff, b2_in;
   rsp_type                   b3_ff, b3_in;
   logic                      b1_v_ff, b2_v_ff, b3_v_ff;
   logic                      en1, en2, en3;
   logic [OWNER_W-1:0]        rank_sum;
   logic [OWNER_W-1:0]        owner;
   logic                      lt;
   logic [OWNER_W+NP_W-1:0]   pf_full;
   logic [STATE_W+NP_W-1:0]   ps_full;
   logic [FLAT_W-1:0]         flat;

   assign en3      = !b3_v_ff || out_ready;
   assign en2      = !b2_v_ff || en3;
   assign en1      = !b1_v_ff || en2;
   assign in_ready = en1;

   // large ranks come first, the rest follow rem
   assign rank_sum = cfg.rem + in_data.quot;
   assign owner    = in_data.low_part ? in_data.quot : rank_sum;
   assign lt       = owner < cfg.rem;

   always_comb begin
      b1_in.in_win = in_data.in_win;
      b1_in.pair   = in_data.pair;
      b1_in.state  = in_data.state;
      b1_in.owner  = owner;
      b1_in.minv   = lt ? owner : cfg.rem;
      b1_in.count  = cfg.base + NP_W'(lt);
      b1_in.value  = in_data.value;
   end

   assign pf_full = b1_ff.owner * cfg.base;
   assign ps_full = b1_ff.state * b1_ff.count;

   always_comb begin
      b2_in.in_win     = b1_ff.in_win;
      b2_in.pair       = b1_ff.pair;
      b2_in.owner      = b1_ff.owner;
      b2_in.minv       = b1_ff.minv;
      b2_in.prod_state = FLAT_W'(ps_full);
      b2_in.prod_first = FLAT_W'(pf_full);
      b2_in.value      = b1_ff.value;
   end

   assign flat = b2_ff.prod_state + FLAT_W'(b2_ff.pair) - b2_ff.prod_first
                 - FLAT_W'(b2_ff.minv);

   always_comb begin
      b3_in.in_block    = b2_ff.in_win;
      b3_in.owner_rank  = b2_ff.in_win ? b2_ff.owner : '0;
      b3_in.flat_index  = b2_ff.in_win ? flat : '0;
      b3_in.out_re_bits = b2_ff.value.re;
      b3_in.out_im_bits = b2_ff.value.im;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_v_ff <= 1'b0;
         b2_v_ff <= 1'b0;
         b3_v_ff <= 1'b0;
      end else begin
         if (en1) begin
            b1_v_ff <= in_valid;
         end
         if (en2) begin
            b2_v_ff <= b1_v_ff;
         end
         if (en3) begin
            b3_v_ff <= b2_v_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en1 && in_valid) begin
         b1_ff <= b1_in;
      end
      if (en2 && b1_v_ff) begin
         b2_ff <= b2_in;
      end
      if (en3 && b2_v_ff) begin
         b3_ff <= b3_in;
      end
   end

   assign out_valid = b3_v_ff;
   assign out_data  = b3_ff;

endmodule

`default_nettype wire

// ===== rtl/block_partition_owner_router.sv =====
// ----------------------------------------------------------------------------
// block_partition_owner_router: owner rank and local index of matrix elements
// tests each element against the selected block, finds the rank owning its
// row under an even block partition and forms the flat local index
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the response side is ready and no
// setup is running, set by the 15-stage pipeline
// (2 front stages, 10 divider stages for the owner quotient, 3 back stages)
// after every register write, requests are held off while the serial divider
// recomputes pairs per rank and the remainder
// reset (synchronous) empties the pipeline and restores the register defaults
`default_nettype none

module block_partition_owner_router (
   input  logic                            clock,
   input  logic                            reset,
   bpor_req_if.sink                        req_ch,
   bpor_rsp_if.source                      rsp_ch,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [bpor_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bpor_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bpor_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);
   import bpor_pkg::*;

   cfg_type  cfg;
   logic     busy;

   req_type  req_data;
   logic     front_valid, front_ready;

   div_type  div_in_data;
   logic     div_in_valid, div_in_ready;
   div_type  div_out_data;
   logic     div_out_valid, div_out_ready;

   rsp_type  rsp_data;

   // registers plus the base/remainder setup divider
   bpor_cfg u_cfg (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg),
      .busy    (busy)
   );

   // no requests taken while the partition setup is being recomputed
   assign front_valid  = req_ch.valid & ~busy;
   assign req_ch.ready = front_ready & ~busy;

   always_comb begin
      req_data.elem_row      = req_ch.elem_row;
      req_data.global_col    = req_ch.global_col;
      req_data.value_re_bits = req_ch.value_re_bits;
      req_data.value_im_bits = req_ch.value_im_bits;
   end

   // window test, pair/state offsets, dividend and divisor
   bpor_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (req_data),
      .cfg       (cfg),
      .out_valid (div_in_valid),
      .out_ready (div_in_ready),
      .out_data  (div_in_data)
   );

   // owner quotient, one bit per stage
   bpor_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_in_valid),
      .in_ready  (div_in_ready),
      .in_data   (div_in_data),
      .out_valid (div_out_valid),
      .out_ready (div_out_ready),
      .out_data  (div_out_data)
   );

   // owner, first pair and count, flat index; last stage is the response register
   bpor_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_out_valid),
      .in_ready  (div_out_ready),
      .in_data   (div_out_data),
      .cfg       (cfg),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .out_data  (rsp_data)
   );

   assign rsp_ch.in_block    = rsp_data.in_block;
   assign rsp_ch.owner_rank  = rsp_data.owner_rank;
   assign rsp_ch.flat_index  = rsp_data.flat_index;
   assign rsp_ch.out_re_bits = rsp_data.out_re_bits;
   assign rsp_ch.out_im_bits = rsp_data.out_im_bits;

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: block partition owner router
// drives matrix elements through the request channel under several partition
// settings and compares every response, field by field, with a typed-in or an
// in-bench computed owner and local index; directed rows, then random streams
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import bpor_pkg::*;

   localparam int CLOCK_HALF      = 5;
   localparam int RESET_CYCLES    = 9;
   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 88;
   localparam int STALL_LIMIT     = 2000;
   localparam int SETTLE_CYCLES   = 40;
   localparam int DIRECTED_ROWS   = 42;

   // register slots with no register behind them
   localparam logic [REG_IDX_W-1:0] REG_SPARE_LOW  = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_SPARE_HIGH = 3'd7;

   localparam logic [VALUE_W-1:0] ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [VALUE_W-1:0] VAL_A  = 64'hAAAA_AAAA_AAAA_AAAA;
   localparam logic [VALUE_W-1:0] VAL_5  = 64'h5555_5555_5555_5555;
   localparam logic [VALUE_W-1:0] VAL_UP = 64'h0123_4567_89AB_CDEF;
   localparam logic [VALUE_W-1:0] VAL_DN = 64'hFEDC_BA98_7654_3210;

   typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;
   typedef enum {ROW_WRITE, ROW_TYPED, ROW_PREDICTED} row_kind_type;

   // one directed step: a register write or a request, with the response
   // typed in for the rows marked ROW_TYPED
   typedef struct {
      row_kind_type         kind;
      logic [REG_IDX_W-1:0] index;
      logic [31:0]          data;
      logic [COORD_W-1:0]   row;
      logic [COORD_W-1:0]   col;
      logic [VALUE_W-1:0]   re;
      logic [VALUE_W-1:0]   im;
      logic                 in_block;
      logic [OWNER_W-1:0]   owner;
      logic [FLAT_W-1:0]    flat;
   } vector_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   bpor_req_if req_ch ();
   bpor_rsp_if rsp_ch ();

   // shadow copy of the partition registers, as last written
   logic [COORD_W-1:0]       row_base   = '0;
   logic [COORD_W-1:0]       col_base   = '0;
   logic [PAIR_COUNT_W-1:0]  pairs_raw  = 21'd1;
   logic [STATE_COUNT_W-1:0] states_raw = 13'd1;
   logic [RANK_COUNT_W-1:0]  ranks_raw  = 11'd1;

   rsp_type       pending_results [$];
   idle_mode_type idle_mode = IDLE_NONE;
   bit            failed = 1'b0;
   int            checked_count = 0;
   int            inside_count = 0;
   int            settings_count = 0;
   int            idle_cycles = 0;

   vector_row_type directed_rows [DIRECTED_ROWS] = '{
      // reset block is the single element at the origin
      '{ROW_TYPED, '0, '0, 24'h000000, 24'h000000, 64'h0, 64'h0, 1'b1, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'h000001, 24'h000000, ONES, ONES, 1'b0, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'hFFFFFF, 24'hFFFFFF, VAL_5, VAL_A, 1'b0, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'h000000, 24'h000001, VAL_A, VAL_5, 1'b0, 10'h0, 32'h0},
      // writes to empty slots leave the block as it was
      '{ROW_WRITE, REG_SPARE_LOW, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_SPARE_HIGH, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_TYPED, '0, '0, 24'h000000, 24'h000000, VAL_UP, VAL_DN, 1'b1, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'h000000, 24'h000001, VAL_DN, VAL_UP, 1'b0, 10'h0, 32'h0},
      // zero counts behave as one
      '{ROW_WRITE, REG_PAIR_COUNT, 32'h0, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_STATE_COUNT, 32'h0, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_RANK_COUNT, 32'h0, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_TYPED, '0, '0, 24'h000000, 24'h000000, VAL_A, VAL_A, 1'b1, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'h000001, 24'h000000, VAL_5, VAL_5, 1'b0, 10'h0, 32'h0},
      // oversized counts saturate; one rank owning every pair gives the top index
      '{ROW_WRITE, REG_PAIR_COUNT, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_STATE_COUNT, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_TYPED, '0, '0, 24'h0FFFFF, 24'h000FFF, ONES, 64'h0, 1'b1, 10'h0,
        32'hFFFF_FFFF},
      '{ROW_TYPED, '0, '0, 24'h100000, 24'h000000, 64'h0, ONES, 1'b0, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'h000000, 24'h001000, VAL_UP, VAL_UP, 1'b0, 10'h0, 32'h0},
      '{ROW_WRITE, REG_RANK_COUNT, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_TYPED, '0, '0, 24'h0FFFFF, 24'h000FFF, VAL_DN, VAL_DN, 1'b1, 10'h3FF,
        32'h003F_FFFF},
      '{ROW_PREDICTED, '0, '0, 24'h07FFFF, 24'h0005AB, VAL_A, VAL_UP, '0, '0, '0},
      // block pushed to the top corner of the index space
      '{ROW_WRITE, REG_ROW_START, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_COLUMN_START, 32'hFFFF_FFFF, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_PAIR_COUNT, 32'd4, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_STATE_COUNT, 32'd3, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_RANK_COUNT, 32'd3, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_TYPED, '0, '0, 24'hFFFFFF, 24'hFFFFFF, VAL_5, VAL_DN, 1'b1, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'hFFFFFE, 24'hFFFFFF, VAL_UP, VAL_5, 1'b0, 10'h0, 32'h0},
      '{ROW_TYPED, '0, '0, 24'hFFFFFF, 24'hFFFFFE, VAL_DN, VAL_A, 1'b0, 10'h0, 32'h0},
      // more ranks than pairs: one pair each for the first ranks
      '{ROW_WRITE, REG_ROW_START, 32'h10, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_COLUMN_START, 32'h20, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_PAIR_COUNT, 32'd3, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_RANK_COUNT, 32'd5, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_STATE_COUNT, 32'd2, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_PREDICTED, '0, '0, 24'h000010, 24'h000020, VAL_UP, ONES, '0, '0, '0},
      '{ROW_PREDICTED, '0, '0, 24'h000012, 24'h000021, ONES, VAL_DN, '0, '0, '0},
      '{ROW_PREDICTED, '0, '0, 24'h000011, 24'h000021, VAL_A, 64'h0, '0, '0, '0},
      '{ROW_TYPED, '0, '0, 24'h000013, 24'h000020, 64'h0, VAL_5, 1'b0, 10'h0, 32'h0},
      // uneven split: two larger ranks then two smaller
      '{ROW_WRITE, REG_PAIR_COUNT, 32'd10, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_WRITE, REG_RANK_COUNT, 32'd4, '0, '0, '0, '0, '0, '0, '0},
      '{ROW_PREDICTED, '0, '0, 24'h000015, 24'h000021, VAL_DN, VAL_UP, '0, '0, '0},
      '{ROW_PREDICTED, '0, '0, 24'h000019, 24'h000021, VAL_5, VAL_A, '0, '0, '0}
   };

   block_partition_owner_router dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   // zero counts read as one, oversized ones stop at the maximum
   function automatic longint unsigned limit_count(input longint unsigned raw,
                                                   input longint unsigned hi);
      if (raw == 0) return 1;
      if (raw > hi) return hi;
      return raw;
   endfunction

   // owner rank and flat local index of one element under the shadow settings
   function automatic rsp_type route_element(input req_type r);
      longint unsigned np, ns, nr, row, col, pair, st;
      longint unsigned per_rank, extra, wide_end, owner, first_idx, owned, flat;
      bit              hit;
      rsp_type         res;
      np  = limit_count(pairs_raw, MAX_PAIRS);
      ns  = limit_count(states_raw, MAX_STATES);
      nr  = limit_count(ranks_raw, MAX_RANKS);
      row = r.elem_row;
      col = r.global_col;
      hit = row >= row_base && row < row_base + np
         && col >= col_base && col < col_base + ns;
      owner = 0;
      flat  = 0;
      if (hit) begin
         pair     = row - row_base;
         st       = col - col_base;
         per_rank = np / nr;
         extra    = np % nr;
         // the first extra ranks hold per_rank+1 pairs each
         wide_end = (per_rank + 1) * extra;
         if (pair < wide_end) begin
            owner = pair / (per_rank + 1);
         end else begin
            owner = extra + (pair - wide_end) / per_rank;
         end
         first_idx = owner * per_rank + (owner < extra ? owner : extra);
         owned     = per_rank + (owner < extra ? 1 : 0);
         flat      = st * owned + pair - first_idx;
      end
      res.in_block    = hit;
      res.owner_rank  = owner[OWNER_W-1:0];
      res.flat_index  = flat[FLAT_W-1:0];
      res.out_re_bits = r.value_re_bits;
      res.out_im_bits = r.value_im_bits;
      return res;
   endfunction

   // mostly elements inside the block, then elements just past an edge,
   // then elements anywhere
   function automatic req_type random_element();
      longint unsigned np, ns, span_r, span_c;
      int              pick;
      req_type         r;
      np     = limit_count(pairs_raw, MAX_PAIRS);
      ns     = limit_count(states_raw, MAX_STATES);
      span_r = (row_base + np > (64'd1 << COORD_W)) ? (64'd1 << COORD_W) - row_base : np;
      span_c = (col_base + ns > (64'd1 << COORD_W)) ? (64'd1 << COORD_W) - col_base : ns;
      pick   = $urandom_range(99);
      r.value_re_bits = {$urandom, $urandom};
      r.value_im_bits = {$urandom, $urandom};
      r.elem_row      = row_base + COORD_W'($urandom_range(32'(span_r - 1)));
      r.global_col    = col_base + COORD_W'($urandom_range(32'(span_c - 1)));
      if (pick >= 85) begin
         r.elem_row   = COORD_W'($urandom);
         r.global_col = COORD_W'($urandom);
      end else if (pick >= 70) begin
         if ($urandom_range(1)) begin
            r.elem_row = $urandom_range(1) ? COORD_W'(row_base + np) : row_base - 1'b1;
         end else begin
            r.global_col = $urandom_range(1) ? COORD_W'(col_base + ns) : col_base - 1'b1;
         end
      end
      return r;
   endfunction

   // starting row or column, with junk in the unused upper bits
   function automatic logic [31:0] pick_start();
      logic [31:0] value;
      case ($urandom_range(3))
         0: value = '0;
         1: value = 32'hFF_FFFF;
         2: value = $urandom_range(255);
         default: value = $urandom & 32'hFF_FFFF;
      endcase
      return ($urandom & 32'hFF00_0000) | value;
   endfunction

   // count register value: mostly small, sometimes zero, full or random
   function automatic logic [31:0] pick_count(input int width, input int common_hi);
      logic [31:0] mask;
      logic [31:0] value;
      mask = (32'd1 << width) - 1;
      case ($urandom_range(9))
         0: value = '0;
         1: value = mask;
         2: value = $urandom & mask;
         default: value = $urandom_range(common_hi, 1);
      endcase
      return ($urandom & ~mask) | value;
   endfunction

   function automatic void compare_field(input string name, input logic [63:0] want,
                                         input logic [63:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         failed = 1'b1;
      end
   endfunction

   // setup phase, access phase, then the bus goes quiet
   task automatic write_register(input logic [REG_IDX_W-1:0] index,
                                 input logic [31:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      case (index)
         REG_ROW_START:    row_base   = data[COORD_W-1:0];
         REG_COLUMN_START: col_base   = data[COORD_W-1:0];
         REG_PAIR_COUNT:   pairs_raw  = data[PAIR_COUNT_W-1:0];
         REG_STATE_COUNT:  states_raw = data[STATE_COUNT_W-1:0];
         REG_RANK_COUNT:   ranks_raw  = data[RANK_COUNT_W-1:0];
         default: ;
      endcase
   endtask

   // hold the sender back until every response has come home
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   // offer one request, with random gaps before it, and log its response
   task automatic send_request(input req_type r, input bit typed, input rsp_type typed_rsp);
      int      gap_pct;
      rsp_type expect_rsp;
      gap_pct = idle_mode == IDLE_SENDER ? 57 : idle_mode == IDLE_BOTH ? 18 : 0;
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.elem_row      <= r.elem_row;
      req_ch.global_col    <= r.global_col;
      req_ch.value_re_bits <= r.value_re_bits;
      req_ch.value_im_bits <= r.value_im_bits;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      expect_rsp      = typed ? typed_rsp : route_element(r);
      pending_results = {pending_results, expect_rsp};
   endtask

   // phase 0 takes the largest counts, phase 1 the smallest block at the top
   // corner, later phases random settings
   task automatic apply_settings(input int phase);
      logic [31:0] rs, cs, pc, sc, rc;
      case (phase)
         0: begin
            rs = '0;  cs = '0;
            pc = '1;  sc = '1;  rc = '1;
         end
         1: begin
            rs = 32'hFF_FFFF;  cs = 32'hFF_FFFF;
            pc = 32'd1;  sc = 32'd1;  rc = 32'd1;
         end
         default: begin
            rs = pick_start();
            cs = pick_start();
            pc = pick_count(PAIR_COUNT_W, 40);
            sc = pick_count(STATE_COUNT_W, 16);
            rc = pick_count(RANK_COUNT_W, 12);
         end
      endcase
      write_register(REG_ROW_START, rs);
      write_register(REG_COLUMN_START, cs);
      write_register(REG_PAIR_COUNT, pc);
      write_register(REG_STATE_COUNT, sc);
      write_register(REG_RANK_COUNT, rc);
      settings_count++;
   endtask

   // response side: random stalls, and each accepted response checked
   // against the oldest request still waiting
   always @(posedge clock) begin
      rsp_type want;
      int      stall_pct;
      stall_pct = idle_mode == IDLE_RECEIVER ? 57 : idle_mode == IDLE_BOTH ? 18 : 0;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= $urandom_range(99) >= stall_pct;
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_results.size() == 0) begin
               $error("response with no request outstanding");
               failed = 1'b1;
            end else begin
               want = pending_results.pop_front();
               compare_field("in_block", want.in_block, rsp_ch.in_block);
               compare_field("owner_rank", want.owner_rank, rsp_ch.owner_rank);
               compare_field("flat_index", want.flat_index, rsp_ch.flat_index);
               compare_field("out_re_bits", want.out_re_bits, rsp_ch.out_re_bits);
               compare_field("out_im_bits", want.out_im_bits, rsp_ch.out_im_bits);
               checked_count++;
               if (want.in_block) inside_count++;
            end
         end
      end
   end

   // watchdog: any handshake or register access counts as progress
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || psel) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no progress for %0d cycles", STALL_LIMIT);
            $display("FAIL block_partition_owner_router");
            $finish;
         end
      end
   end

   initial begin
      vector_row_type vec;
      req_type        item;
      rsp_type        want;
      req_ch.valid         <= 1'b0;
      req_ch.elem_row      <= '0;
      req_ch.global_col    <= '0;
      req_ch.value_re_bits <= '0;
      req_ch.value_im_bits <= '0;
      psel                 <= 1'b0;
      penable              <= 1'b0;
      pwrite               <= 1'b0;
      paddr                <= '0;
      pwdata               <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed rows, with light idling on both sides
      idle_mode = IDLE_BOTH;
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         vec = directed_rows[i];
         if (vec.kind == ROW_WRITE) begin
            drain_results();
            write_register(vec.index, vec.data);
         end else begin
            item = '{vec.row, vec.col, vec.re, vec.im};
            want = '{vec.in_block, vec.owner, vec.flat, vec.re, vec.im};
            send_request(item, vec.kind == ROW_TYPED, want);
         end
      end

      // random streams, one register setting and one idle pattern per phase
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain_results();
         apply_settings(phase);
         idle_mode = idle_mode_type'(phase % 4);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // one full drain in the middle of a stream
            if (phase == 2 && n == ITEMS_PER_PHASE / 2) drain_results();
            send_request(random_element(), 1'b0, '0);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("checked %0d responses, %0d inside the block, over %0d random settings",
               checked_count, inside_count, settings_count);
      $display("ran with no idling, sender gaps, receiver stalls, both, and a full drain");
      if (!failed && pending_results.size() == 0) begin
         $display("PASS block_partition_owner_router");
      end else begin
         $display("FAIL block_partition_owner_router");
      end
      $finish;
   end

endmodule
